// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the keyer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge outside reset.
`define MLK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cond never holds outside reset.
`define MLK_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: hdl/mlk_pkg.sv
// ----------------------------------------------------------------------------
// mlk_pkg
// Types, constants and the character pattern ROM of the Morse LED keyer.
// ----------------------------------------------------------------------------
package mlk_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int QW          = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int BANK_DEPTH  = QUEUE_DEPTH / 2;
  localparam int BANK_AW     = QW - 1;

  localparam logic [15:0] PAT_DASH_MASK = 16'hC000;
  localparam logic [15:0] PAT_DOT_MASK  = 16'h8000;
  localparam logic [15:0] PAT_INVALID   = 16'hFFFF;
  localparam logic [15:0] PAT_BLANK     = 16'h0001;

  localparam logic [7:0] ASCII_SPACE   = 8'd32;
  localparam logic [7:0] ASCII_DIGIT_0 = 8'd48;
  localparam logic [7:0] ASCII_DIGIT_9 = 8'd57;
  localparam logic [7:0] ASCII_UPPER_A = 8'd65;
  localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
  localparam logic [7:0] ASCII_LOWER_A = 8'd97;
  localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
  localparam logic [7:0] UPPER_OFFSET  = 8'd55;
  localparam logic [7:0] LOWER_OFFSET  = 8'd87;

  localparam logic [3:0] DASH_HOLD_RESET = 4'd2;

  localparam logic ACTION_PUSH = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  localparam logic REG_DASH_HOLD = 1'b0;

  localparam int ROM_DEPTH = 36;
  localparam logic [15:0] MORSE_ROM [ROM_DEPTH] = '{
    16'hDB6C, 16'hB6D8, 16'hADB0, 16'hAB60, 16'hAAC0,
    16'hAA80, 16'hD540, 16'hDAA0, 16'hDB50, 16'hDB68,
    16'hB000, 16'hD500, 16'hD680, 16'hD400, 16'h8000,
    16'hAD00, 16'hDA00, 16'hAA00, 16'hA000, 16'hB6C0,
    16'hD600, 16'hB500, 16'hD800, 16'hD000, 16'hDB00,
    16'hB680, 16'hDAC0, 16'hB400, 16'hA800, 16'hC000,
    16'hAC00, 16'hAB00, 16'hB600, 16'hD580, 16'hD6C0,
    16'hDA80
  };

  typedef struct packed {
    logic       action;
    logic [7:0] character;
    logic       end_of_word;
  } mlk_cmd_t;

  typedef struct packed {
    logic       led_on;
    logic       char_dropped;
    logic [5:0] queue_count;
    logic       busy_res;
  } mlk_res_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] character;
    logic       end_of_word;
  } mlk_qctl_t;

  function automatic logic [15:0] char_pattern(input logic [7:0] c);
    logic [5:0]  idx;
    logic [15:0] pat;
    idx = '0;
    pat = PAT_INVALID;
    if (c >= ASCII_DIGIT_0 && c <= ASCII_DIGIT_9) begin
      idx = 6'(c - ASCII_DIGIT_0);
      pat = MORSE_ROM[idx];
    end else if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
      idx = 6'(c - UPPER_OFFSET);
      pat = MORSE_ROM[idx];
    end else if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
      idx = 6'(c - LOWER_OFFSET);
      pat = MORSE_ROM[idx];
    end else if (c == ASCII_SPACE) begin
      pat = PAT_BLANK;
    end
    return pat;
  endfunction

endpackage

// File: hdl/morse_led_keyer_core.sv
// ----------------------------------------------------------------------------
// morse_led_keyer_core
// Morse code LED keyer: queued ASCII characters sent as dots and dashes.
// ----------------------------------------------------------------------------
// Each command beat is either a push of one ASCII character (optionally
// followed by a word space) or one timing tick, and gives exactly one result
// beat. One beat is taken per clock while cmd_stall is low; each command
// passes through the input register, the single update stage and then the
// result register. The 32-slot queue is two interleaved RAM banks, so a
// character and its word space are written in the same cycle, and the head
// character is prefetched every cycle. The dash hold register sits at byte
// address 0 and should only be written while the keyer idles.
`include "assert_macros.svh"

module morse_led_keyer_core
  import mlk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  mlk_cmd_t    cmd,
  output logic        res_valid,
  input  logic        res_stall,
  output mlk_res_t    res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             s1_valid;
  mlk_cmd_t         s1;
  logic             advance;
  logic             accept;
  logic [3:0]       dash_hold;
  mlk_qctl_t        qctl;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic [7:0]       head_char;
  logic             dropped;
  logic             pop;
  logic             led_next;
  logic             busy_next;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DASH_HOLD) ? {28'd0, dash_hold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dash_hold <= DASH_HOLD_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_DASH_HOLD) begin
      dash_hold <= pwdata[3:0];
    end
  end

  assign advance   = s1_valid && (!res_valid || !res_stall);
  assign cmd_stall = s1_valid && !advance;
  assign accept    = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
    if (accept) begin
      s1 <= cmd;
    end
    if (advance) begin
      res.led_on       <= led_next;
      res.char_dropped <= (s1.action == ACTION_PUSH) && dropped;
      res.queue_count  <= 6'(fill_next);
      res.busy_res     <= busy_next;
    end
  end

  always_comb begin
    qctl.push        = s1.action == ACTION_PUSH;
    qctl.pop         = pop;
    qctl.character   = s1.character;
    qctl.end_of_word = s1.end_of_word;
  end

  mlk_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .ctl       (qctl),
    .fill      (fill),
    .fill_next (fill_next),
    .head_char (head_char),
    .dropped   (dropped)
  );

  mlk_keyer u_keyer (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .tick           (s1.action == ACTION_TICK),
    .dash_hold      (dash_hold),
    .queue_nonempty (fill != '0),
    .head_char      (head_char),
    .pop            (pop),
    .led_next       (led_next),
    .busy_next      (busy_next)
  );

  `MLK_ASSERT(a_advance_result, clk, rst, advance |=> res_valid, "processed beat left no result")
  `MLK_ASSERT(a_stall_pending, clk, rst, cmd_stall |-> s1_valid && res_valid, "stall without pending beats")

endmodule

// File: hdl/mlk_ram.sv
// ----------------------------------------------------------------------------
// mlk_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module mlk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/mlk_queue.sv
// ----------------------------------------------------------------------------
// mlk_queue
// Character queue: two interleaved RAM banks so a push and its word space
// land in one cycle, with the head character prefetched every cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlk_queue
  import mlk_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  mlk_qctl_t        ctl,
  output logic [CNT_W-1:0] fill,
  output logic [CNT_W-1:0] fill_next,
  output logic [7:0]       head_char,
  output logic             dropped
);

  logic [QW-1:0]      head;
  logic [QW-1:0]      head_next;
  logic [QW-1:0]      tail;
  logic [QW-1:0]      tail1;
  logic               room;
  logic               take;
  logic [1:0]         bank_wr_en;
  logic [BANK_AW-1:0] bank_wr_addr [2];
  logic [7:0]         bank_wr_data [2];
  logic [7:0]         bank_rd_data [2];
  logic [7:0]         bank_q       [2];
  logic [1:0]         byp_valid;
  logic [7:0]         byp_data     [2];

  assign room    = fill <= CNT_W'(QUEUE_DEPTH - 2);
  assign take    = step && ctl.push && room;
  assign dropped = ctl.push && !room;
  assign tail    = head + fill[QW-1:0];
  assign tail1   = tail + QW'(1);

  always_comb begin
    fill_next = fill;
    head_next = head;
    if (take) begin
      fill_next = fill + CNT_W'(1) + CNT_W'(ctl.end_of_word);
    end else if (step && ctl.pop) begin
      fill_next = fill - CNT_W'(1);
      head_next = head + QW'(1);
    end
  end

  for (genvar b = 0; b < 2; b++) begin : g_bank
    always_comb begin
      bank_wr_en[b] = take && ((tail[0] == 1'(b)) || (ctl.end_of_word && tail1[0] == 1'(b)));
      if (tail[0] == 1'(b)) begin
        bank_wr_addr[b] = tail[QW-1:1];
        bank_wr_data[b] = ctl.character;
      end else begin
        bank_wr_addr[b] = tail1[QW-1:1];
        bank_wr_data[b] = ASCII_SPACE;
      end
    end

    mlk_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk     (clk),
      .wr_en   (bank_wr_en[b]),
      .wr_addr (bank_wr_addr[b]),
      .wr_data (bank_wr_data[b]),
      .rd_addr (head_next[QW-1:1]),
      .rd_data (bank_rd_data[b])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        byp_valid[b] <= 1'b0;
      end else begin
        byp_valid[b] <= bank_wr_en[b] && (bank_wr_addr[b] == head_next[QW-1:1]);
      end
      byp_data[b] <= bank_wr_data[b];
    end

    assign bank_q[b] = byp_valid[b] ? byp_data[b] : bank_rd_data[b];
  end

  assign head_char = bank_q[head[0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  `MLK_NEVER(a_fill_bound, clk, rst, fill > CNT_W'(QUEUE_DEPTH), "queue fill beyond depth")
  `MLK_ASSERT(a_drop_holds, clk, rst, step && dropped |=> $stable(fill) && $stable(head), "dropped push changed the queue")

endmodule

// File: hdl/mlk_keyer.sv
// ----------------------------------------------------------------------------
// mlk_keyer
// Keyer state machine: fetch a pattern, shift out dots and dashes, drive LED.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlk_keyer
  import mlk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       tick,
  input  logic [3:0] dash_hold,
  input  logic       queue_nonempty,
  input  logic [7:0] head_char,
  output logic       pop,
  output logic       led_next,
  output logic       busy_next
);

  typedef enum logic [1:0] {
    IDLE = 2'd0,
    PROC = 2'd1,
    DASH = 2'd2,
    DOT  = 2'd3
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [15:0] pattern;
  logic [15:0] pattern_next;
  logic [15:0] fetched;
  logic [3:0]  hold;
  logic [3:0]  hold_next;
  logic        led;

  assign fetched = char_pattern(head_char);

  always_comb begin
    state_next   = state;
    pattern_next = pattern;
    hold_next    = hold;
    led_next     = led;
    pop          = 1'b0;
    if (tick) begin
      unique case (state)
        IDLE: begin
          if (queue_nonempty) begin
            pop          = 1'b1;
            pattern_next = fetched;
            if (fetched != PAT_INVALID) begin
              state_next = PROC;
            end
          end
        end
        PROC: begin
          if ((pattern & PAT_DASH_MASK) == PAT_DASH_MASK) begin
            pattern_next = pattern << 3;
            hold_next    = dash_hold;
            state_next   = DASH;
            led_next     = 1'b1;
          end else if ((pattern & PAT_DOT_MASK) == PAT_DOT_MASK) begin
            pattern_next = pattern << 2;
            state_next   = DOT;
            led_next     = 1'b1;
          end else begin
            state_next = IDLE;
          end
        end
        DASH: begin
          if (hold != 4'd0) begin
            hold_next = hold - 4'd1;
          end else begin
            state_next = PROC;
            led_next   = 1'b0;
          end
        end
        DOT: begin
          state_next = PROC;
          led_next   = 1'b0;
        end
        default: begin
          state_next = IDLE;
        end
      endcase
    end
  end

  assign busy_next = state_next != IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      pattern <= '0;
      hold    <= '0;
      led     <= 1'b0;
    end else if (step) begin
      state   <= state_next;
      pattern <= pattern_next;
      hold    <= hold_next;
      led     <= led_next;
    end
  end

  `MLK_ASSERT(a_led_state, clk, rst, led |-> (state == DASH || state == DOT), "LED lit outside an element")
  `MLK_ASSERT(a_pop_idle, clk, rst, pop |-> (state == IDLE && tick), "dequeue outside idle tick")

endmodule
